// ----- hdl/dfe_pkg.sv -----
// Shared constants and types for the delimiter frame extractor.
`default_nettype none
package dfe_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int MARKER_BYTES    = 6;
  localparam int MARKER_W        = 8 * MARKER_BYTES;
  localparam int COUNT_W         = 7;
  localparam int LIMIT_W         = 6;
  localparam int LEN_W           = 6;
  localparam int CFG_INDEX_W     = 2;
  // Wide enough to hold any store address up to the largest supported depth.
  localparam int ADDR_EXT_W      = 9;

  localparam logic [MARKER_W-1:0] MARKER_RESET = 48'hD5AE77BD42CD;
  localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = 6'd57;

  localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OVERFLOW_LIMIT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } dfe_state_t;

endpackage
`default_nettype wire

// ----- hdl/dfe_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module dfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- hdl/dfe_window.sv -----
// Six-byte shift window of received bytes and its compare against the end marker.
`default_nettype none
module dfe_window (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         shift_en,
  input  wire logic [7:0]                   rx_byte,
  input  wire logic [dfe_pkg::MARKER_W-1:0] end_marker,
  output logic                              match
);

  // Oldest byte sits in the most significant position, as in the marker.
  logic [dfe_pkg::MARKER_W-1:0] window;
  logic [dfe_pkg::MARKER_W-1:0] window_next;

  always_comb begin
    window_next = {window[dfe_pkg::MARKER_W-9:0], rx_byte};
    match       = (window_next == end_marker);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
    end else if (shift_en) begin
      window <= window_next;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/delimiter_frame_extractor.sv -----
// Top level: byte intake, frame store control and payload output register.
//
//   channel   dir  handshake          contents
//   s_*       in   s_tvalid/s_tready  tdata: rx_byte
//   m_*       out  m_tvalid/m_tready  tdata: payload_byte, frame_length; tlast; tuser
//   cfg_*     in   cfg_we             cfg_index selects end marker or overflow limit
//
// A received byte is written to the frame store (while the count lies within the store
// depth) and shifted into the marker window in the same cycle. A frame of N payload
// bytes then drains through a store read state and an output load state per byte,
// the load waiting on a stalled output, and no byte is taken meanwhile; the store read
// data is registered, and each read is issued only after the previous byte is loaded.
// Reset clears the state, the count, the window and the output valid and restores the
// configuration registers to their defaults; the store and the output data are not
// cleared. A stalled output holds its transaction and blocks further intake.
`default_nettype none
module delimiter_frame_extractor #(
  parameter int STORE_DEPTH = dfe_pkg::STORE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [15:0]                          m_tdata,   // [7:0] payload_byte,
                                                          // [13:8] frame_length
  output logic                                 m_tlast,   // last
  output logic                                 m_tuser,   // [0] empty_frame
  input  wire logic                            cfg_we,
  input  wire logic [dfe_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dfe_pkg::MARKER_W-1:0]    cfg_data
);

  localparam int AW = $clog2(STORE_DEPTH);

  logic [dfe_pkg::MARKER_W-1:0] end_marker;
  logic [dfe_pkg::LIMIT_W-1:0]  overflow_limit;

  dfe_pkg::dfe_state_t state;
  dfe_pkg::dfe_state_t state_next;

  logic [dfe_pkg::COUNT_W-1:0] byte_count;
  logic [dfe_pkg::COUNT_W-1:0] count_inc;
  logic [dfe_pkg::LEN_W-1:0]   frame_len;
  logic [dfe_pkg::LEN_W-1:0]   len_new;
  logic [dfe_pkg::LEN_W-1:0]   rd_idx;
  logic [dfe_pkg::LEN_W-1:0]   rd_idx_inc;

  logic                        in_acc;
  logic                        match;
  logic                        short_frame;
  logic                        out_free;
  logic                        drain_load;
  logic                        drain_last;
  logic                        rd_oob;
  logic                        store_we;

  logic [dfe_pkg::ADDR_EXT_W-1:0] waddr_ext;
  logic [dfe_pkg::ADDR_EXT_W-1:0] raddr_ext;
  logic [7:0]                     ram_rdata;

  logic [7:0]                 out_byte;
  logic                       out_last;
  logic                       out_empty;
  logic [dfe_pkg::LEN_W-1:0]  out_len;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      end_marker     <= dfe_pkg::MARKER_RESET;
      overflow_limit <= dfe_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == dfe_pkg::REG_END_MARKER) begin
        end_marker <= cfg_data;
      end else if (cfg_index == dfe_pkg::REG_OVERFLOW_LIMIT) begin
        overflow_limit <= cfg_data[dfe_pkg::LIMIT_W-1:0];
      end
    end
  end

  dfe_window u_window (
    .clk        (clk),
    .rst        (rst),
    .shift_en   (in_acc),
    .rx_byte    (s_tdata),
    .end_marker (end_marker),
    .match      (match)
  );

  // Writes happen only while idle; the read port reads every cycle, but its data is used
  // only while draining, so no write meets a read whose data is used.
  dfe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (store_we),
    .waddr (waddr_ext[AW-1:0]),
    .wdata (s_tdata),
    .raddr (raddr_ext[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_free    = !m_tvalid || m_tready;
    in_acc      = s_tvalid && s_tready;
    count_inc   = byte_count + dfe_pkg::COUNT_W'(1);
    short_frame = (count_inc <= dfe_pkg::COUNT_W'(dfe_pkg::MARKER_BYTES));
    len_new     = dfe_pkg::LEN_W'(count_inc - dfe_pkg::COUNT_W'(dfe_pkg::MARKER_BYTES));
    waddr_ext   = dfe_pkg::ADDR_EXT_W'(byte_count);
    raddr_ext   = dfe_pkg::ADDR_EXT_W'(rd_idx);
    store_we    = in_acc && (32'(byte_count) < STORE_DEPTH);
    rd_idx_inc  = rd_idx + dfe_pkg::LEN_W'(1);
    drain_last  = (rd_idx_inc == frame_len);
    // Positions past the end of the store read as zero.
    rd_oob      = (32'(rd_idx) >= STORE_DEPTH);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      dfe_pkg::ST_IDLE: begin
        if (in_acc && match && !short_frame) begin
          state_next = dfe_pkg::ST_READ;
        end
      end
      dfe_pkg::ST_READ: begin
        state_next = dfe_pkg::ST_LOAD;
      end
      dfe_pkg::ST_LOAD: begin
        if (out_free) begin
          state_next = drain_last ? dfe_pkg::ST_IDLE : dfe_pkg::ST_READ;
        end
      end
      default: begin
        state_next = dfe_pkg::ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    s_tready   = 1'b0;
    drain_load = 1'b0;
    unique case (state)
      dfe_pkg::ST_IDLE: s_tready   = out_free;
      dfe_pkg::ST_READ: ;
      dfe_pkg::ST_LOAD: drain_load = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dfe_pkg::ST_IDLE;
      byte_count <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (match) begin
          byte_count <= '0;
        end else if (count_inc > dfe_pkg::COUNT_W'(overflow_limit)) begin
          byte_count <= '0;
        end else begin
          byte_count <= count_inc;
        end
      end
      if (in_acc && match && short_frame) begin
        m_tvalid <= 1'b1;
      end else if (drain_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Drain bookkeeping and output payload.
  always_ff @(posedge clk) begin
    if (in_acc && match) begin
      frame_len <= len_new;
      rd_idx    <= '0;
    end else if (drain_load) begin
      rd_idx <= rd_idx_inc;
    end
    if (in_acc && match && short_frame) begin
      out_byte  <= '0;
      out_last  <= 1'b1;
      out_empty <= 1'b1;
      out_len   <= '0;
    end else if (drain_load) begin
      out_byte  <= rd_oob ? 8'd0 : ram_rdata;
      out_last  <= drain_last;
      out_empty <= 1'b0;
      out_len   <= frame_len;
    end
  end

  assign m_tdata = {2'b00, out_len, out_byte};
  assign m_tlast = out_last;
  assign m_tuser = out_empty;

endmodule
`default_nettype wire
